/* design/touch_affine_calibration_map_defines.svh */
// ----------------------------------------------------------------------------
// Touch affine calibration map - assertion macros
// Shared property shorthands; they expect clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef TOUCH_AFFINE_CALIBRATION_MAP_DEFINES_SVH
`define TOUCH_AFFINE_CALIBRATION_MAP_DEFINES_SVH

// same-cycle implication
`define TACM_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TACM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tacm_pkg.sv */
// ----------------------------------------------------------------------------
// tacm_pkg
// Types and constants shared by the touch calibration map modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tacm_pkg;

  localparam int unsigned IN_W       = 12;  // raw converter field width
  localparam int unsigned DISP_W     = 16;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned QUO_BITS   = DISP_W + 1;
  localparam int unsigned LANE_LAT   = QUO_BITS + 5;
  localparam int unsigned CMD_DEPTH  = 4;
  localparam int unsigned OUT_DEPTH  = 32;
  localparam int unsigned NUM_REGS   = 7;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_CAL = 1'b1;

  localparam logic signed [DISP_W-1:0] DISP_MAX = {1'b0, {(DISP_W-1){1'b1}}};
  localparam logic signed [DISP_W-1:0] DISP_MIN = {1'b1, {(DISP_W-1){1'b0}}};
  localparam logic [QUO_BITS-1:0] QUO_POS_LIM = {2'b00, {(DISP_W-1){1'b1}}};
  localparam logic [QUO_BITS-1:0] QUO_NEG_LIM = {2'b01, {(DISP_W-1){1'b0}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_A  = 3'd0,
    REG_COEF_B  = 3'd1,
    REG_COEF_C  = 3'd2,
    REG_COEF_D  = 3'd3,
    REG_COEF_E  = 3'd4,
    REG_COEF_F  = 3'd5,
    REG_DIVISOR = 3'd6
  } tacm_reg_e;

  typedef struct packed {
    logic [IN_W-1:0] screen_x;
    logic [IN_W-1:0] screen_y;
  } tacm_in_t;

  typedef struct packed {
    logic signed [DISP_W-1:0] disp_x;
    logic signed [DISP_W-1:0] disp_y;
    logic                     status;
  } tacm_out_t;

  // classified item held between front and back
  typedef struct packed {
    logic            div_zero;
    logic [IN_W-1:0] screen_x;
    logic [IN_W-1:0] screen_y;
  } tacm_cmd_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic signed [COEF_W-1:0] coef_e;
    logic signed [COEF_W-1:0] coef_f;
    logic signed [COEF_W-1:0] divisor;
  } tacm_coef_t;

endpackage

/* design/tacm_fifo.sv */
// ----------------------------------------------------------------------------
// tacm_fifo
// Small flop-based first-in first-out queue with registered storage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tacm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/tacm_front.sv */
// ----------------------------------------------------------------------------
// tacm_front
// Accepts raw points, tags them uncalibrated or not, and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tacm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tacm_pkg::tacm_in_t  item_i,
  output logic                full_o,
  input  logic                div_zero_i,
  output tacm_pkg::tacm_cmd_t cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_pop_i
);

  import tacm_pkg::*;

  tacm_cmd_t cmd_in;
  logic      cmd_empty;

  always_comb begin
    cmd_in.div_zero = div_zero_i;
    cmd_in.screen_x = item_i.screen_x;
    cmd_in.screen_y = item_i.screen_y;
  end

  tacm_fifo #(
    .WIDTH ($bits(tacm_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

/* design/tacm_lane.sv */
// ----------------------------------------------------------------------------
// tacm_lane
// One coordinate: gain/offset sum, pipelined restoring divide, saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tacm_lane #(
  parameter int unsigned USE_W = 12
) (
  input  logic                                clk_i,
  input  logic signed [tacm_pkg::COEF_W-1:0]  gain_x_i,
  input  logic signed [tacm_pkg::COEF_W-1:0]  gain_y_i,
  input  logic signed [tacm_pkg::COEF_W-1:0]  offset_i,
  input  logic        [tacm_pkg::COEF_W-1:0]  dmag_i,
  input  logic                                div_neg_i,
  input  logic        [USE_W-1:0]             sx_i,
  input  logic        [USE_W-1:0]             sy_i,
  output logic signed [tacm_pkg::DISP_W-1:0]  coord_o
);

  import tacm_pkg::*;

  localparam int unsigned PROD_W = COEF_W + USE_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned SHL_W  = COEF_W + QUO_BITS;
  localparam int unsigned REM_W  = (SUM_W > SHL_W) ? SUM_W : SHL_W;

  logic signed [PROD_W-1:0] prod_x_d, prod_x_q, prod_y_d, prod_y_q;
  logic [SUM_W-1:0]         sum_d, sum_q, mag_d, mag_q;
  logic                     neg_q;
  logic [REM_W-1:0]         rem_init, div_full;

  logic [REM_W-1:0]    rem_q   [QUO_BITS+1];
  logic [QUO_BITS-1:0] quo_q   [QUO_BITS+1];
  logic                ovf_q   [QUO_BITS+1];
  logic                sgn_q   [QUO_BITS+1];
  logic [REM_W-1:0]    div_shl [QUO_BITS];
  logic [REM_W-1:0]    rem_nxt [QUO_BITS];
  logic [QUO_BITS-1:0] quo_nxt [QUO_BITS];

  logic [QUO_BITS-1:0]      quo_fin;
  logic [QUO_BITS-1:0]      quo_neg;
  logic signed [DISP_W-1:0] coord_d, coord_q;

  assign prod_x_d = PROD_W'(gain_x_i) * PROD_W'($signed({1'b0, sx_i}));
  assign prod_y_d = PROD_W'(gain_y_i) * PROD_W'($signed({1'b0, sy_i}));

  assign sum_d = {prod_x_q[PROD_W-1], prod_x_q}
               + {prod_y_q[PROD_W-1], prod_y_q}
               + {{(SUM_W-COEF_W){offset_i[COEF_W-1]}}, offset_i};

  assign mag_d = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;

  // quotient of 2^QUO_BITS or more always saturates
  assign rem_init = REM_W'(mag_q);
  assign div_full = REM_W'(dmag_i) << QUO_BITS;

  always_comb begin
    for (int k = 0; k < QUO_BITS; k++) begin
      div_shl[k] = REM_W'(dmag_i) << (QUO_BITS - 1 - k);
      if (rem_q[k] >= div_shl[k]) begin
        rem_nxt[k] = rem_q[k] - div_shl[k];
        quo_nxt[k] = quo_q[k] | (QUO_BITS'(1) << (QUO_BITS - 1 - k));
      end else begin
        rem_nxt[k] = rem_q[k];
        quo_nxt[k] = quo_q[k];
      end
    end
  end

  assign quo_fin = quo_q[QUO_BITS];
  assign quo_neg = ~quo_fin + QUO_BITS'(1);

  always_comb begin
    if (ovf_q[QUO_BITS]) begin
      coord_d = sgn_q[QUO_BITS] ? DISP_MIN : DISP_MAX;
    end else if (sgn_q[QUO_BITS]) begin
      coord_d = (quo_fin > QUO_NEG_LIM) ? DISP_MIN : $signed(quo_neg[DISP_W-1:0]);
    end else begin
      coord_d = (quo_fin > QUO_POS_LIM) ? DISP_MAX : $signed(quo_fin[DISP_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    sum_q    <= sum_d;
    mag_q    <= mag_d;
    neg_q    <= sum_q[SUM_W-1] ^ div_neg_i;
    rem_q[0] <= rem_init;
    quo_q[0] <= '0;
    ovf_q[0] <= (rem_init >= div_full);
    sgn_q[0] <= neg_q;
    for (int k = 0; k < QUO_BITS; k++) begin
      rem_q[k+1] <= rem_nxt[k];
      quo_q[k+1] <= quo_nxt[k];
      ovf_q[k+1] <= ovf_q[k];
      sgn_q[k+1] <= sgn_q[k];
    end
    coord_q <= coord_d;
  end

  assign coord_o = coord_q;

endmodule

/* design/tacm_back.sv */
// ----------------------------------------------------------------------------
// tacm_back
// Issues queued points into both coordinate lanes and buffers the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tacm_back #(
  parameter int unsigned USE_W = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tacm_pkg::tacm_cmd_t  cmd_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_pop_o,
  input  tacm_pkg::tacm_coef_t coef_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output tacm_pkg::tacm_out_t  result_o
);

  import tacm_pkg::*;

  localparam int unsigned OCC_W = $clog2(OUT_DEPTH + 1);

  logic [COEF_W-1:0]        dmag_q;
  logic                     div_neg_q;
  logic [OCC_W-1:0]         occ_q, occ_d;
  logic                     issue, out_pop, out_full;
  logic [LANE_LAT-1:0]      vld_q, zero_q;
  logic signed [DISP_W-1:0] lane_x, lane_y;
  tacm_out_t                res_in;

  // credit: items in flight plus buffered never exceed the output queue
  assign issue     = cmd_valid_i && (occ_q != OCC_W'(OUT_DEPTH)) && !out_full;
  assign cmd_pop_o = issue;
  assign out_pop   = pop_i && !empty_o;

  always_comb begin
    occ_d = occ_q;
    if (issue && !out_pop) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (out_pop && !issue) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      vld_q <= '0;
    end else begin
      occ_q <= occ_d;
      vld_q <= {vld_q[LANE_LAT-2:0], issue};
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q    <= {zero_q[LANE_LAT-2:0], cmd_i.div_zero};
    div_neg_q <= coef_i.divisor[COEF_W-1];
    dmag_q    <= coef_i.divisor[COEF_W-1] ? (~coef_i.divisor + COEF_W'(1))
                                          : coef_i.divisor;
  end

  tacm_lane #(.USE_W(USE_W)) u_lane_x (
    .clk_i     (clk_i),
    .gain_x_i  (coef_i.coef_a),
    .gain_y_i  (coef_i.coef_b),
    .offset_i  (coef_i.coef_c),
    .dmag_i    (dmag_q),
    .div_neg_i (div_neg_q),
    .sx_i      (cmd_i.screen_x[USE_W-1:0]),
    .sy_i      (cmd_i.screen_y[USE_W-1:0]),
    .coord_o   (lane_x)
  );

  tacm_lane #(.USE_W(USE_W)) u_lane_y (
    .clk_i     (clk_i),
    .gain_x_i  (coef_i.coef_d),
    .gain_y_i  (coef_i.coef_e),
    .offset_i  (coef_i.coef_f),
    .dmag_i    (dmag_q),
    .div_neg_i (div_neg_q),
    .sx_i      (cmd_i.screen_x[USE_W-1:0]),
    .sy_i      (cmd_i.screen_y[USE_W-1:0]),
    .coord_o   (lane_y)
  );

  always_comb begin
    if (zero_q[LANE_LAT-1]) begin
      res_in.disp_x = '0;
      res_in.disp_y = '0;
      res_in.status = STATUS_NO_CAL;
    end else begin
      res_in.disp_x = lane_x;
      res_in.disp_y = lane_y;
      res_in.status = STATUS_OK;
    end
  end

  tacm_fifo #(
    .WIDTH ($bits(tacm_out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (vld_q[LANE_LAT-1]),
    .data_i  (res_in),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (result_o),
    .empty_o (empty_o)
  );

endmodule

/* design/touch_affine_calibration_map.sv */
// Path: a point passes the command queue, then 22 stages (multiply, sum,
//   magnitude, range check, 17 restoring-divide steps, saturate) before the
//   result queue. Throughput: one point per cycle while the result queue
//   has room; each divide step has its own subtractor.
// Reset: calibration registers clear to zero (uncalibrated), queues empty.
// ----------------------------------------------------------------------------
// touch_affine_calibration_map
// Maps raw touch points to display coordinates with an affine matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_affine_calibration_map #(
  parameter int unsigned SCREEN_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  input  tacm_pkg::tacm_in_t                   in_item_i,
  output logic                                 full,
  output logic                                 empty,
  input  logic                                 pop,
  output tacm_pkg::tacm_out_t                  result_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tacm_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [tacm_pkg::COEF_W-1:0]          pwdata,
  output logic [tacm_pkg::COEF_W-1:0]          prdata,
  output logic                                 pready
);

  import tacm_pkg::*;

  localparam int unsigned USE_W = (SCREEN_BITS < IN_W) ? SCREEN_BITS : IN_W;

  logic [COEF_W-1:0]    cfg_q [NUM_REGS];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_hit;
  tacm_coef_t           coef;
  tacm_cmd_t            cmd;
  logic                 cmd_valid, cmd_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign reg_hit = (reg_idx < REG_IDX_W'(NUM_REGS));
  assign prdata  = reg_hit ? cfg_q[reg_idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      cfg_q[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    coef.coef_a  = cfg_q[REG_COEF_A];
    coef.coef_b  = cfg_q[REG_COEF_B];
    coef.coef_c  = cfg_q[REG_COEF_C];
    coef.coef_d  = cfg_q[REG_COEF_D];
    coef.coef_e  = cfg_q[REG_COEF_E];
    coef.coef_f  = cfg_q[REG_COEF_F];
    coef.divisor = cfg_q[REG_DIVISOR];
  end

  tacm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .div_zero_i  (cfg_q[REG_DIVISOR] == '0),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  tacm_back #(.USE_W(USE_W)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .coef_i      (coef),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

/* design/tacm_checker.sv */
// ----------------------------------------------------------------------------
// tacm_checker
// Port-level properties of the touch calibration map, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "touch_affine_calibration_map_defines.svh"

module tacm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input tacm_pkg::tacm_out_t result_o
);

  import tacm_pkg::*;

  // input queue only fills through accepted items
  `TACM_ASSERT_IMPLY(a_full_rise_on_push, $rose(full), $past(push && !full), "full rose without an item")

  // result queue only drains through pops
  `TACM_ASSERT_IMPLY(a_empty_rise_on_pop, $rose(empty), $past(pop), "empty rose without a pop")

  // uncalibrated results carry zero coordinates
  `TACM_ASSERT_IMPLY(a_nocal_zero, !empty && result_o.status == STATUS_NO_CAL, result_o.disp_x == '0 && result_o.disp_y == '0, "uncalibrated result not zero")

  `TACM_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result_o), "waiting result changed")

endmodule

bind touch_affine_calibration_map tacm_checker u_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
